FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DefCapacity = 16;

  localparam logic [2:0] OP_READ       = 3'd0;
  localparam logic [2:0] OP_INSERT_HD  = 3'd1;
  localparam logic [2:0] OP_INSERT_TL  = 3'd2;
  localparam logic [2:0] OP_INSERT_AT  = 3'd3;
  localparam logic [2:0] OP_DELETE_AT  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } ple_cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [4:0]         length;
  } ple_rsp_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_UP,
    SHIFT_DOWN
  } ple_shift_e;

  typedef struct packed {
    ple_shift_e  kind;
    logic [31:0] value;
  } ple_shift_t;

endpackage

FILE: design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, takes the new value, its left neighbor
// (insert) or its right neighbor (delete) according to the broadcast
// shift command and its own index.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic             clk,
  input  ple_shift_t       shift,
  input  logic [CNT_W-1:0] pos,
  input  logic [31:0]      left,
  input  logic [31:0]      right,
  output logic [31:0]      value
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic [31:0] value_next;

  always_comb begin
    value_next = value;
    case (shift.kind)
      SHIFT_UP: begin
        if (Idx == pos) begin
          value_next = shift.value;
        end else if (Idx > pos) begin
          value_next = left;
        end
      end
      SHIFT_DOWN: begin
        if (Idx >= pos) begin
          value_next = right;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: design/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of 32-bit entries kept in a row of cells; insert and delete
// shift every later cell by one place, all cells together.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | word
//  in      | cmd_valid | cmd_stall | cmd (opcode, position, item_value)
//  out     | rsp_valid | rsp_stall | rsp (read_value, status, length)
//
//  One word per cycle while cmd_stall is low; each operation finishes in the cycle it is taken,
//  set by the one-step shift across the cell row.
//  Response appears in the cycle after acceptance, from an output register.
//  cmd_stall is high only while a response is held by rsp_stall.
//  Reset clears the length; entry contents are undefined until written.
// ----------------------------------------------------------------------------
module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  ple_cmd_t cmd,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output ple_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned RD_N  = (CAPACITY < 32) ? CAPACITY : 32;
  localparam logic [CNT_W-1:0] Full = CNT_W'(CAPACITY);

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] cnt_cmp;
  logic [CNT_W-1:0] shift_pos;
  ple_shift_t       shift;
  logic [31:0]      rd_data;
  logic [31:0]      cell_q [CAPACITY];
  logic             rsp_valid_next;
  ple_rsp_t         rsp_next;

  assign cmd_stall = rsp_valid & rsp_stall;
  assign accept    = cmd_valid & ~cmd_stall;
  assign pos_cmp   = CMP_W'(cmd.position);
  assign cnt_cmp   = CMP_W'(count);

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_cmp == CMP_W'(i)) begin
        rd_data = cell_q[i];
      end
    end
  end

  always_comb begin
    shift      = '{kind: SHIFT_HOLD, value: cmd.item_value};
    shift_pos  = CNT_W'(pos_cmp);
    count_next = count;
    rsp_next   = '{read_value: '0, status: ST_RANGE, length: '0};
    case (cmd.opcode)
      OP_READ: begin
        if (pos_cmp < cnt_cmp) begin
          rsp_next.read_value = rd_data;
          rsp_next.status     = ST_DONE;
        end else begin
          rsp_next.read_value = -32'sd1;
        end
      end
      OP_INSERT_HD, OP_INSERT_TL, OP_INSERT_AT: begin
        if (cmd.opcode == OP_INSERT_HD) begin
          shift_pos = '0;
        end else if (cmd.opcode == OP_INSERT_TL) begin
          shift_pos = count;
        end
        if (cmd.opcode == OP_INSERT_AT && pos_cmp > cnt_cmp) begin
          rsp_next.status = ST_RANGE;
        end else if (count == Full) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.status = ST_DONE;
          shift.kind      = SHIFT_UP;
          count_next      = count + CNT_W'(1);
        end
      end
      OP_DELETE_AT: begin
        if (pos_cmp < cnt_cmp) begin
          rsp_next.status = ST_DONE;
          shift.kind      = SHIFT_DOWN;
          count_next      = count - CNT_W'(1);
        end
      end
      default: rsp_next.status = ST_RANGE;
    endcase
    rsp_next.length = 5'(count_next);
    if (!accept) begin
      shift.kind = SHIFT_HOLD;
      count_next = count;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [31:0] left;
      logic [31:0] right;
      if (g == 0) begin : g_first
        assign left = cell_q[g];
      end else begin : g_mid_l
        assign left = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right = cell_q[g];
      end else begin : g_mid_r
        assign right = cell_q[g+1];
      end
      ple_cell #(
        .CNT_W (CNT_W),
        .INDEX (g)
      ) u_cell (
        .clk   (clk),
        .shift (shift),
        .pos   (shift_pos),
        .left  (left),
        .right (right),
        .value (cell_q[g])
      );
    end
  endgenerate

  assign rsp_valid_next = accept | (rsp_valid & rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("list length above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && rsp_next.status == ST_FULL |-> count == Full)
    else $error("full status with room left");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && shift.kind == SHIFT_UP |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_held_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp) && $stable(count))
    else $error("response or length changed while stalled");
`endif

endmodule

FILE: dv/positional_list_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_top_test
// Self-checking bench for the positional list engine. A mirror list is
// updated on every accepted command word and predicts each response word.
// A short directed table covers the empty and full list, the range misses,
// insert-order checks and the spare opcodes. Random traffic follows,
// biased to grow and shrink the list end to end, under several idle and
// stall mixes and one long response hold-off.
// ----------------------------------------------------------------------------
module positional_list_engine_top_test;
  import ple_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned RandWordsPerPhase = 200;

  typedef struct {
    ple_cmd_t    word;
    int unsigned reps;
    bit          known;
    ple_rsp_t    want;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  ple_cmd_t cmd = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  ple_rsp_t rsp;

  logic signed [31:0] list_mirror [DefCapacity];
  int unsigned        list_len = 0;
  bit                 list_growing = 1'b1;
  ple_rsp_t           results_due [$];
  ple_rsp_t           oldest_due;
  plan_row_t          direct_plan [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_active = 1'b0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned peak_len = 0;
  int unsigned full_refusals = 0;
  int unsigned range_misses = 0;

  positional_list_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("positional_list_engine_top regression: fail");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("[%0t] response %0d %s: got %h want %h", $realtime, words_checked, what,
             got, want);
  endtask

  function automatic logic [1:0] mirror_insert(input int unsigned at,
                                               input logic signed [31:0] v);
    if (at > list_len) return ST_RANGE;
    if (list_len >= DefCapacity) return ST_FULL;
    for (int i = list_len; i > int'(at); i--) list_mirror[i] = list_mirror[i - 1];
    list_mirror[at] = v;
    list_len++;
    return ST_DONE;
  endfunction

  function automatic ple_rsp_t list_step(input ple_cmd_t c);
    ple_rsp_t r;
    r = '0;
    case (c.opcode)
      OP_READ: begin
        if (c.position < list_len) begin
          r.read_value = list_mirror[c.position];
          r.status = ST_DONE;
        end else begin
          r.read_value = -32'sd1;
          r.status = ST_RANGE;
        end
      end
      OP_INSERT_HD: r.status = mirror_insert(0, c.item_value);
      OP_INSERT_TL: r.status = mirror_insert(list_len, c.item_value);
      OP_INSERT_AT: r.status = mirror_insert(c.position, c.item_value);
      OP_DELETE_AT: begin
        if (c.position >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = c.position; i + 1 < int'(list_len); i++) begin
            list_mirror[i] = list_mirror[i + 1];
          end
          list_len--;
          r.status = ST_DONE;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.length = 5'(list_len);
    return r;
  endfunction

  function automatic plan_row_t plan_predicted(input logic [2:0] op,
                                               input logic [4:0] pos,
                                               input logic signed [31:0] v,
                                               input int unsigned reps);
    plan_row_t p;
    p.word = '{opcode: op, position: pos, item_value: v};
    p.reps = reps;
    p.known = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic plan_row_t plan_known(input logic [2:0] op, input logic [4:0] pos,
                                           input logic signed [31:0] v,
                                           input logic signed [31:0] rv,
                                           input logic [1:0] st, input logic [4:0] len);
    plan_row_t p;
    p = plan_predicted(op, pos, v, 1);
    p.known = 1'b1;
    p.want = '{read_value: rv, status: st, length: len};
    return p;
  endfunction

  // offer one command word, wait for it to be taken, queue its response
  task automatic offer_word(input ple_cmd_t w, input bit known, input ple_rsp_t known_rsp);
    ple_rsp_t want;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (cmd_stall);
    want = list_step(w);
    words_sent++;
    if (list_len > peak_len) peak_len = list_len;
    if (want.status == ST_FULL) full_refusals++;
    if (want.status == ST_RANGE) range_misses++;
    results_due.push_back(known ? known_rsp : want);
  endtask

  task automatic run_random_words(input int unsigned count);
    ple_cmd_t    w;
    int unsigned sub;
    int unsigned ins_pct;
    int unsigned del_pct;
    for (int unsigned n = 0; n < count; n++) begin
      w.opcode = 3'($urandom_range(0, 7));
      w.position = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 11))
        0: w.item_value = 32'sh7FFFFFFF;
        1: w.item_value = 32'sh80000000;
        2: w.item_value = -32'sd1;
        default: w.item_value = $urandom();
      endcase
      if (list_len == 0) list_growing = 1'b1;
      if (list_len == DefCapacity && $urandom_range(0, 3) == 0) list_growing = 1'b0;
      if ($urandom_range(0, 99) < 85) begin
        sub = $urandom_range(0, 99);
        ins_pct = list_growing ? 60 : 15;
        del_pct = list_growing ? 15 : 60;
        if (sub < ins_pct) begin
          case ($urandom_range(0, 2))
            0: w.opcode = OP_INSERT_HD;
            1: w.opcode = OP_INSERT_TL;
            default: w.opcode = OP_INSERT_AT;
          endcase
          w.position = 5'($urandom_range(0, list_len));
        end else if (list_len > 0) begin
          w.opcode = (sub < ins_pct + del_pct) ? OP_DELETE_AT : OP_READ;
          w.position = 5'($urandom_range(0, list_len - 1));
        end
      end
      offer_word(w, 1'b0, '0);
    end
  endtask

  task automatic wait_drained;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (results_due.size() == 0) begin
          note_mismatch("word with no response pending", rsp.read_value, '0);
        end else begin
          oldest_due = results_due.pop_front();
          if (rsp.read_value !== oldest_due.read_value) begin
            note_mismatch("read_value", rsp.read_value, oldest_due.read_value);
          end
          if (rsp.status !== oldest_due.status) begin
            note_mismatch("status", 32'(rsp.status), 32'(oldest_due.status));
          end
          if (rsp.length !== oldest_due.length) begin
            note_mismatch("length", 32'(rsp.length), 32'(oldest_due.length));
          end
        end
        words_checked++;
      end
      rsp_stall <= hold_active || ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  initial begin
    direct_plan = '{
      plan_known(OP_READ, 5'd0, 32'sd0, -32'sd1, ST_RANGE, 5'd0),
      plan_known(OP_DELETE_AT, 5'd0, 32'sd0, 32'sd0, ST_RANGE, 5'd0),
      plan_known(OP_INSERT_AT, 5'd1, 32'sh1234, 32'sd0, ST_RANGE, 5'd0),
      plan_known(OP_SPARE_HI, 5'd31, -32'sd1, 32'sd0, ST_RANGE, 5'd0),
      plan_known(OP_INSERT_HD, 5'd0, 32'sh7FFFFFFF, 32'sd0, ST_DONE, 5'd1),
      plan_known(OP_INSERT_TL, 5'd31, 32'sh80000000, 32'sd0, ST_DONE, 5'd2),
      plan_predicted(OP_INSERT_AT, 5'd1, -32'sd1, 1),
      plan_predicted(OP_READ, 5'd0, 32'sd0, 1),
      plan_predicted(OP_READ, 5'd1, 32'sd0, 1),
      plan_predicted(OP_READ, 5'd2, 32'sd0, 1),
      plan_known(OP_READ, 5'd31, 32'sd0, -32'sd1, ST_RANGE, 5'd3),
      plan_known(OP_INSERT_AT, 5'd4, 32'sd5, 32'sd0, ST_RANGE, 5'd3),
      plan_predicted(OP_INSERT_AT, 5'd3, 32'sh55AA55AA, 1),
      plan_predicted(OP_DELETE_AT, 5'd1, 32'sd0, 1),
      plan_known(OP_DELETE_AT, 5'd31, 32'sd0, 32'sd0, ST_RANGE, 5'd3),
      plan_known(OP_SPARE_LO, 5'd31, -32'sd1, 32'sd0, ST_RANGE, 5'd3),
      plan_predicted(OP_INSERT_TL, 5'd0, 32'sh0F0F0000, 13),
      plan_known(OP_INSERT_HD, 5'd0, 32'sd1, 32'sd0, ST_FULL, 5'd16),
      plan_known(OP_INSERT_AT, 5'd16, 32'sd1, 32'sd0, ST_FULL, 5'd16),
      // position check wins over full check
      plan_known(OP_INSERT_AT, 5'd17, 32'sd1, 32'sd0, ST_RANGE, 5'd16),
      plan_known(OP_INSERT_TL, 5'd0, 32'sd1, 32'sd0, ST_FULL, 5'd16),
      plan_predicted(OP_READ, 5'd15, 32'sd0, 1),
      plan_predicted(OP_DELETE_AT, 5'd0, 32'sd0, 16),
      plan_known(OP_READ, 5'd0, 32'sd0, -32'sd1, ST_RANGE, 5'd0)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (direct_plan[i]) begin
      for (int unsigned r = 0; r < direct_plan[i].reps; r++) begin
        ple_cmd_t w;
        w = direct_plan[i].word;
        w.item_value = w.item_value + r;
        offer_word(w, direct_plan[i].known, direct_plan[i].want);
      end
    end
    cmd_valid <= 1'b0;
    wait_drained();

    // no idling, with a long response hold-off to back up the command side
    fork
      run_random_words(RandWordsPerPhase);
      begin
        hold_active <= 1'b1;
        repeat (40) @(posedge clk);
        hold_active <= 1'b0;
      end
    join
    cmd_valid <= 1'b0;
    wait_drained();

    tx_idle_pct = 60;
    run_random_words(RandWordsPerPhase);
    cmd_valid <= 1'b0;
    wait_drained();

    tx_idle_pct = 0;
    rx_stall_pct <= 60;
    run_random_words(RandWordsPerPhase);
    cmd_valid <= 1'b0;
    wait_drained();

    tx_idle_pct = 13;
    rx_stall_pct <= 13;
    run_random_words(RandWordsPerPhase);
    cmd_valid <= 1'b0;
    wait_drained();

    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      note_mismatch("responses never seen", 32'(results_due.size()), '0);
    end
    $display("%0d commands sent, %0d responses checked, %0d mismatches", words_sent,
             words_checked, mismatches);
    $display("list peaked at %0d entries; %0d full refusals, %0d out-of-range results",
             peak_len, full_refusals, range_misses);
    if (mismatches == 0) begin
      $display("positional_list_engine_top regression: pass");
    end else begin
      $display("positional_list_engine_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: positional_list_engine_top.f
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine_top.sv
dv/positional_list_engine_top_test.sv
